[sv/assert_macros.svh]
// Assertion macros used by the RTL of the pressure/temperature compensation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define BPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define BPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/bpt_pkg.sv]
// Package: widths, constants and register indexes of the compensation pipeline
package bpt_pkg;

  localparam int unsigned RawW    = 24;
  localparam int unsigned CalW    = 16;
  localparam int unsigned DtW     = 25;
  localparam int unsigned ProdW   = 41;
  localparam int unsigned TempW   = 19;
  localparam int unsigned SqW     = 38;
  localparam int unsigned OffW    = 42;
  localparam int unsigned PressW  = 32;
  localparam int unsigned LoW     = 21;
  localparam int unsigned PlW     = 45;
  localparam int unsigned PhW     = 46;
  localparam int unsigned XW      = 47;
  localparam int unsigned YW      = 48;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned NumStages = 7;
  localparam int unsigned CalIdxW = 3;

  localparam logic signed [TempW-1:0] TempRef  = 19'sd2000;
  localparam logic signed [TempW-1:0] TempCold = -19'sd1500;

  typedef enum logic [CalIdxW-1:0] {
    CAL_SENS      = 3'd0,
    CAL_OFFSET    = 3'd1,
    CAL_TCS       = 3'd2,
    CAL_TCO       = 3'd3,
    CAL_TREF      = 3'd4,
    CAL_TEMPSENS  = 3'd5
  } cal_idx_e;

endpackage

[sv/baro_pressure_temp_compensation.sv]
// Barometric sensor compensation: seven-stage pipeline from raw D1/D2 to pascals and centidegrees
//
// Usage:
//   Slave stream: s_tdata_i carries one raw pressure (D1) and one raw temperature (D2)
//   conversion; each transfer yields exactly one result on the master stream.
//   Master stream: m_tdata_o carries the compensated pressure in pascals (low 32 bits)
//   and the temperature in hundredths of a degree.
//   Calibration words C1..C6 are written on cfg_we_i/cfg_idx_i/cfg_data_i (index 0..5,
//   others ignored); the user does so only while no item is in flight; the block does not enforce this.
// Timing:
//   Throughput is one item per cycle while m_tready_i is high; seven register stages
//   (subtract, three multiplies, scale/offset, two squares, correction, split 42x24
//   multiply, final shift) lie between an accepted item and its result on m_tvalid_o.
//   The widest product, D1 times sensitivity, is split into two halves of at most 25x21
//   bits in one stage and merged in the last one.
// Reset: clears every stage valid bit and all calibration words to zero.
// Stall: when m_tready_i is low, the output holds; earlier stages keep advancing into
//   empty slots, so s_tready_o stays high until every stage holds an item.
module baro_pressure_temp_compensation
  import bpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CalIdxW-1:0]  cfg_idx_i,
  input  logic [CalW-1:0]     cfg_data_i,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [InDataW-1:0]  s_tdata_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // [31:0] pressure_pa, [50:32] temperature_centi, [55:51] zero
  output logic [OutDataW-1:0] m_tdata_o
);

  // calibration words
  logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CAL_SENS:     c1_q <= cfg_data_i;
        CAL_OFFSET:   c2_q <= cfg_data_i;
        CAL_TCS:      c3_q <= cfg_data_i;
        CAL_TCO:      c4_q <= cfg_data_i;
        CAL_TREF:     c5_q <= cfg_data_i;
        CAL_TEMPSENS: c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NumStages:1] valid_q;
  logic [NumStages:1] en;

  always_comb begin
    en[NumStages] = !valid_q[NumStages] || m_tready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_tready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) valid_q[1] <= s_tvalid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 1: temperature difference
  logic [RawW-1:0]        d1_s1_q;
  logic signed [DtW-1:0]  dt_s1_q, dt_s1_d;

  assign dt_s1_d = $signed({1'b0, s_tdata_i[2*RawW-1:RawW]})
                 - $signed({1'b0, c5_q, 8'b0});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_s1_q <= s_tdata_i[RawW-1:0];
      dt_s1_q <= dt_s1_d;
    end
  end

  // stage 2: dT times C6, C4, C3
  logic [RawW-1:0]          d1_s2_q;
  logic signed [ProdW-1:0]  pt_s2_q, po_s2_q, ps_s2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      d1_s2_q <= d1_s1_q;
      pt_s2_q <= ProdW'(dt_s1_q) * ProdW'($signed({1'b0, c6_q}));
      po_s2_q <= ProdW'(dt_s1_q) * ProdW'($signed({1'b0, c4_q}));
      ps_s2_q <= ProdW'(dt_s1_q) * ProdW'($signed({1'b0, c3_q}));
    end
  end

  // stage 3: temperature, first-order offset and sensitivity
  logic [RawW-1:0]          d1_s3_q;
  logic signed [TempW-1:0]  temp_s3_q, temp_s3_d;
  logic signed [OffW-1:0]   off_s3_q, off_s3_d, sens_s3_q, sens_s3_d;

  assign temp_s3_d = TempRef + TempW'($signed(pt_s2_q[ProdW-1:23]));
  assign off_s3_d  = $signed({10'b0, c2_q, 16'b0}) + OffW'($signed(po_s2_q[ProdW-1:7]));
  assign sens_s3_d = $signed({11'b0, c1_q, 15'b0}) + OffW'($signed(ps_s2_q[ProdW-1:8]));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d1_s3_q   <= d1_s2_q;
      temp_s3_q <= temp_s3_d;
      off_s3_q  <= off_s3_d;
      sens_s3_q <= sens_s3_d;
    end
  end

  // stage 4: squares for the second-order terms
  logic [RawW-1:0]          d1_s4_q;
  logic signed [TempW-1:0]  temp_s4_q, dlow_s4_d, dcold_s4_d;
  logic signed [OffW-1:0]   off_s4_q, sens_s4_q;
  logic signed [SqW-1:0]    dsq_s4_q, esq_s4_q;
  logic                     low_s4_q, cold_s4_q;

  assign dlow_s4_d  = temp_s3_q - TempRef;
  assign dcold_s4_d = temp_s3_q - TempCold;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      d1_s4_q   <= d1_s3_q;
      temp_s4_q <= temp_s3_q;
      off_s4_q  <= off_s3_q;
      sens_s4_q <= sens_s3_q;
      dsq_s4_q  <= SqW'(dlow_s4_d) * SqW'(dlow_s4_d);
      esq_s4_q  <= SqW'(dcold_s4_d) * SqW'(dcold_s4_d);
      low_s4_q  <= temp_s3_q < TempRef;
      cold_s4_q <= temp_s3_q < TempCold;
    end
  end

  // stage 5: apply corrections (squares are non-negative and below 2^36)
  logic [RawW-1:0]          d1_s5_q;
  logic signed [TempW-1:0]  temp_s5_q;
  logic signed [OffW-1:0]   off_s5_q, sens_s5_q, off_s5_d, sens_s5_d;
  logic [OffW-1:0]          dsq_x, esq_x, q5, off_lo, sens_lo, off_co, sens_co;

  always_comb begin
    dsq_x   = OffW'(dsq_s4_q[SqW-2:0]);
    esq_x   = OffW'(esq_s4_q[SqW-2:0]);
    q5      = (dsq_x << 2) + dsq_x;
    off_lo  = low_s4_q  ? (q5 >> 1) : '0;
    sens_lo = low_s4_q  ? (q5 >> 2) : '0;
    off_co  = cold_s4_q ? ((esq_x << 3) - esq_x) : '0;
    sens_co = cold_s4_q ? (((esq_x << 3) + (esq_x << 1) + esq_x) >> 1) : '0;
    off_s5_d  = off_s4_q  - $signed(off_lo)  - $signed(off_co);
    sens_s5_d = sens_s4_q - $signed(sens_lo) - $signed(sens_co);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      d1_s5_q   <= d1_s4_q;
      temp_s5_q <= temp_s4_q;
      off_s5_q  <= off_s5_d;
      sens_s5_q <= sens_s5_d;
    end
  end

  // stage 6: D1 times sensitivity, split at bit 21
  logic signed [TempW-1:0]  temp_s6_q;
  logic signed [OffW-1:0]   off_s6_q;
  logic [PlW-1:0]           pl_s6_q;
  logic signed [PhW-1:0]    ph_s6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      temp_s6_q <= temp_s5_q;
      off_s6_q  <= off_s5_q;
      pl_s6_q   <= PlW'(d1_s5_q) * PlW'(sens_s5_q[LoW-1:0]);
      ph_s6_q   <= PhW'($signed({1'b0, d1_s5_q})) * PhW'($signed(sens_s5_q[OffW-1:LoW]));
    end
  end

  // stage 7: merge halves, subtract offset, scale down
  logic signed [XW-1:0]     x_s7_d;
  logic signed [YW-1:0]     y_s7_d;
  logic signed [TempW-1:0]  temp_s7_q;
  logic [PressW-1:0]        press_s7_q;

  assign x_s7_d = XW'(ph_s6_q) + $signed({{(XW-(PlW-LoW)){1'b0}}, pl_s6_q[PlW-1:LoW]});
  assign y_s7_d = YW'(x_s7_d) - YW'(off_s6_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      temp_s7_q  <= temp_s6_q;
      press_s7_q <= y_s7_d[PressW+14:15];
    end
  end

  assign m_tvalid_o = valid_q[NumStages];
  assign m_tdata_o  = {{(OutDataW-PressW-TempW){1'b0}}, temp_s7_q, press_s7_q};

`include "assert_macros.svh"

  `BPT_ASSERT(a_accept_fills_s1, s_tvalid_i && s_tready_o |=> valid_q[1], "accepted item missing in stage 1")
  `BPT_ASSERT_ALWAYS(a_ready_if_room, !(&valid_q) |-> s_tready_o, "ready low with an empty stage")
  `BPT_ASSERT(a_cold_is_low, valid_q[4] && cold_s4_q |-> low_s4_q, "cold correction without low correction")
  `BPT_ASSERT(a_stall_holds_out, valid_q[7] && !m_tready_i |=> valid_q[7] && $stable(press_s7_q), "output stage changed while stalled")

endmodule

[tb/baro_comp_checker.sv]
// Checker for the compensation block: mirrors calibration, predicts readings, compares results
module baro_comp_checker
  import bpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CalIdxW-1:0]  cfg_idx_i,
  input  logic [CalW-1:0]     cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_o,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_o,
  input  logic                m_tready_i,
  // [31:0] pressure_pa, [50:32] temperature_centi, [55:51] zero
  input  logic [OutDataW-1:0] m_tdata_o,
  output int                  error_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  below_ref_o,
  output int                  below_cold_o
);

  localparam int NumCal = int'(CAL_TEMPSENS) + 1;

  // packed from the msb down, so pressure lands in the low bits as on the bus
  typedef struct packed {
    logic signed [TempW-1:0]  temperature_centi;
    logic signed [PressW-1:0] pressure_pa;
  } reading_t;

  logic [CalW-1:0] cal_word [NumCal];
  reading_t        pending_readings [$];
  reading_t        want;
  reading_t        got;
  int              errors     = 0;
  int              checked    = 0;
  int              below_ref  = 0;
  int              below_cold = 0;

  function automatic reading_t compensate(input logic [RawW-1:0] d1_raw,
                                          input logic [RawW-1:0] d2_raw);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, off, sens, temp, dlt, sq, e, p;
    reading_t r;
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    c1 = longint'(cal_word[CAL_SENS]);
    c2 = longint'(cal_word[CAL_OFFSET]);
    c3 = longint'(cal_word[CAL_TCS]);
    c4 = longint'(cal_word[CAL_TCO]);
    c5 = longint'(cal_word[CAL_TREF]);
    c6 = longint'(cal_word[CAL_TEMPSENS]);
    dt   = d2 - c5 * 256;
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    temp = longint'(TempRef) + ((dt * c6) >>> 23);
    // second-order correction of offset and sensitivity; temperature stays as is
    if (temp < longint'(TempRef)) begin
      dlt  = temp - longint'(TempRef);
      sq   = 5 * dlt * dlt;
      off  = off - (sq >>> 1);
      sens = sens - (sq >>> 2);
      if (temp < longint'(TempCold)) begin
        e    = temp - longint'(TempCold);
        e    = e * e;
        off  = off - 7 * e;
        sens = sens - ((11 * e) >>> 1);
      end
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.pressure_pa       = p[PressW-1:0];
    r.temperature_centi = temp[TempW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCal; i++) cal_word[i] <= '0;
      pending_readings.delete();
      error_count_o <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      below_ref_o   <= 0;
      below_cold_o  <= 0;
    end else begin
      // spare indexes fall through and are dropped
      if (cfg_we_i && cfg_idx_i <= CAL_TEMPSENS) cal_word[cfg_idx_i] <= cfg_data_i;

      if (m_tvalid_o && m_tready_i) begin
        got = reading_t'(m_tdata_o[PressW+TempW-1:0]);
        if (pending_readings.size() == 0) begin
          $error("result transfer with no expected reading: pressure_pa %0d, temperature_centi %0d",
                 got.pressure_pa, got.temperature_centi);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          checked++;
          if (got.pressure_pa !== want.pressure_pa) begin
            $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, got.pressure_pa);
            errors++;
          end
          if (got.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   want.temperature_centi, got.temperature_centi);
            errors++;
          end
        end
      end

      if (s_tvalid_i && s_tready_o) begin
        want = compensate(s_tdata_i[RawW-1:0], s_tdata_i[2*RawW-1:RawW]);
        if (want.temperature_centi < TempRef) below_ref++;
        if (want.temperature_centi < TempCold) below_cold++;
        pending_readings.push_back(want);
      end

      error_count_o <= errors;
      pending_o     <= pending_readings.size();
      checked_o     <= checked;
      below_ref_o   <= below_ref;
      below_cold_o  <= below_cold;
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, calibration phases, raw sample stimulus and verdict
module tb;
  import bpt_pkg::*;

  localparam int ClkPeriod        = 8;
  localparam int ResetCycles      = 12;
  localparam int TimeoutCycles    = 400000;
  localparam int NumSettings      = 8;
  localparam int RandomPerSetting = 69;
  localparam int SettleCycles     = 12;

  localparam logic [CalIdxW-1:0] CalSpareLo = 3'd6;
  localparam logic [CalIdxW-1:0] CalSpareHi = 3'd7;
  localparam logic [RawW-1:0]    RawMax     = '1;
  localparam logic [RawW-1:0]    TypicalD1  = 24'd9085466;
  localparam logic [RawW-1:0]    TypicalD2  = 24'd8569150;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CalIdxW-1:0]  cfg_idx_i  = '0;
  logic [CalW-1:0]     cfg_data_i = '0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  // [23:0] raw_pressure, [47:24] raw_temperature
  logic [InDataW-1:0]  s_tdata_i  = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  // [31:0] pressure_pa, [50:32] temperature_centi, [55:51] zero
  logic [OutDataW-1:0] m_tdata_o;

  int errors, pending, checked, below_ref, below_cold;

  int          items_sent      = 0;
  int          settings_loaded = 0;
  int          burst_left      = 0;
  logic [15:0] cal_c5          = '0;
  logic [15:0] cal_c6          = '0;

  rx_mode_e rx_mode      = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_run_left  = 0;

  baro_pressure_temp_compensation u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  baro_comp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_o    (s_tready_o),
    .s_tdata_i     (s_tdata_i),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_o     (m_tdata_o),
    .error_count_o (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .below_ref_o   (below_ref),
    .below_cold_o  (below_cold)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // receiver: switch between stall patterns, each picked at random
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(40, 160);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_tready_i <= 1'b1;
      RX_COIN:   m_tready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_run_left == 0) begin
          m_tready_i  <= ~m_tready_i;
          rx_run_left <= $urandom_range(1, 20);
        end else begin
          rx_run_left <= rx_run_left - 1;
        end
      end
    endcase
  end

  function automatic logic [RawW-1:0] clamp_raw(input longint v);
    if (v < 0) return '0;
    if (v > longint'(RawMax)) return RawMax;
    return v[RawW-1:0];
  endfunction

  function automatic logic [CalW-1:0] rand_cal();
    return CalW'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [RawW-1:0] rand_raw();
    return RawW'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // lowest raw temperature that still reads at or above the target, for the loaded setting
  function automatic longint d2_for_temp(input longint target);
    longint span;
    span = (longint'(TempRef) - target) <<< 23;
    if (cal_c6 == 0) return longint'(cal_c5) * 256;
    return longint'(cal_c5) * 256 - span / longint'(cal_c6);
  endfunction

  task automatic write_cal(input logic [CalIdxW-1:0] idx, input logic [CalW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_calibration(input logic [CalW-1:0] c1, input logic [CalW-1:0] c2,
                                  input logic [CalW-1:0] c3, input logic [CalW-1:0] c4,
                                  input logic [CalW-1:0] c5, input logic [CalW-1:0] c6);
    // spare indexes must not disturb the real words
    write_cal(CalSpareLo, rand_cal());
    write_cal(CalSpareHi, rand_cal());
    write_cal(CAL_SENS, c1);
    write_cal(CAL_OFFSET, c2);
    write_cal(CAL_TCS, c3);
    write_cal(CAL_TCO, c4);
    write_cal(CAL_TREF, c5);
    write_cal(CAL_TEMPSENS, c6);
    cfg_we_i <= 1'b0;
    cal_c5 = c5;
    cal_c6 = c6;
    settings_loaded++;
  endtask

  task automatic send_reading(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    int gap;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {d2, d1};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // drop valid, drain the pipeline, then let it settle before touching calibration
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int               mode;
    longint           v;
    logic [RawW-1:0]  d1;
    logic [RawW-1:0]  d2;
    logic [RawW-1:0]  ref_d2;
    logic [RawW-1:0]  cold_d2;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // calibration still at its reset value
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(TypicalD1, TypicalD2);
    wait_idle();

    load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    ref_d2  = clamp_raw(d2_for_temp(longint'(TempRef)));
    cold_d2 = clamp_raw(d2_for_temp(longint'(TempCold)));
    send_reading('0, '0);
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    send_reading(RawMax, RawMax);
    send_reading(TypicalD1, TypicalD2);
    // both sides of the 20 degree and -15 degree thresholds
    send_reading(TypicalD1, ref_d2);
    send_reading(TypicalD1, clamp_raw(longint'(ref_d2) - 1));
    send_reading(RawMax, clamp_raw(longint'(ref_d2) - 1));
    send_reading(TypicalD1, cold_d2);
    send_reading(TypicalD1, clamp_raw(longint'(cold_d2) - 1));
    send_reading(RawMax, clamp_raw(longint'(cold_d2) - 1));
    send_reading('0, clamp_raw(longint'(cold_d2) - 1));
    send_reading(TypicalD1, clamp_raw(longint'(ref_d2) + 1));
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);

    for (int phase = 0; phase < NumSettings; phase++) begin
      wait_idle();
      case (phase)
        0: load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        1: load_calibration('1, '1, '1, '1, '1, '1);
        2: load_calibration('0, '0, '0, '0, '0, '0);
        4: begin
          // deep cold: reference and slope at full scale
          load_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), '1, '1);
        end
        5: begin
          load_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), '0, rand_cal());
        end
        6: begin
          load_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(), '0);
        end
        default: begin
          load_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(),
                           rand_cal());
        end
      endcase

      repeat (RandomPerSetting) begin
        mode = $urandom_range(0, 15);
        if (mode == 0) d1 = '0;
        else if (mode == 1) d1 = RawMax;
        else d1 = rand_raw();

        mode = $urandom_range(0, 9);
        if (mode <= 2) begin
          d2 = rand_raw();
        end else if (mode <= 4) begin
          v  = d2_for_temp(longint'(TempRef)) + longint'($urandom_range(0, 8192)) - 4096;
          d2 = clamp_raw(v);
        end else if (mode <= 7) begin
          v  = longint'(clamp_raw(d2_for_temp(longint'(TempCold))));
          d2 = clamp_raw(longint'($urandom_range(0, 24'hFFFFFF)) % (v + 1));
        end else if (mode == 8) begin
          v  = d2_for_temp(longint'(TempCold)) + longint'($urandom_range(0, 64)) - 32;
          d2 = clamp_raw(v);
        end else begin
          d2 = ($urandom_range(0, 1) == 0) ? '0 : RawMax;
        end
        send_reading(d1, d2);
      end
    end

    wait_idle();
    $display("Run covered %0d raw sample pairs over %0d calibration settings, %0d results checked",
             items_sent, settings_loaded, checked);
    $display("  %0d readings below 20 degrees, %0d of them below -15 degrees",
             below_ref, below_cold);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results still expected", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/bpt_pkg.sv
sv/baro_pressure_temp_compensation.sv
tb/baro_comp_checker.sv
tb/tb.sv
